>>> hdl/assert_macros.svh
// Assertion macros for the keystream unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, cond, nxt) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, cond, nxt)
`endif
`endif

>>> hdl/arxks_pkg.sv
`default_nettype none
package arxks_pkg;
    localparam int unsigned NumKeyRegs = 6;
    localparam logic [31:0] GoldenConst = 32'h9e3779b9;
    localparam logic [31:0] ConstC = 32'h6a09e667;
    localparam logic [31:0] ConstD = 32'hbb67ae85;

    typedef struct packed {
        logic load_key;
        logic exp_step;
        logic blk_init;
        logic rnd_step;
        logic ks_load;
    } t_dp_cmd;

    typedef struct packed {
        logic exp_done;
        logic rnd_done;
    } t_dp_sts;

    function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned n);
        rotl32 = (v << n) | (v >> (32 - n));
    endfunction
endpackage
`default_nettype wire

>>> hdl/arx_counter_keystream_xor_unit.sv
// Within a keystream block each byte is XORed with the keystream and registered
// at the output; a new block passes ST_INIT and ST_RND, preceded by ST_LOADK and
// ST_EXP for key expansion after a key write. Keystream generation is set by the
// single round unit iterating one round per cycle.
// Reset: synchronous active-low; clears key registers, state, counter, position, schedule flag, output valid.
`default_nettype none
`include "assert_macros.svh"
module arx_counter_keystream_xor_unit #(
    parameter int unsigned ROUNDS = 24
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_out_byte,
    output logic             o_out_last,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);
    import arxks_pkg::*;

    logic [63:0] r_key [NumKeyRegs];
    logic [6*64-1:0] key_flat;
    logic cfg_wr;
    logic [2:0] reg_idx;
    t_dp_cmd cmd;
    t_dp_sts sts;
    logic [127:0] ks;
    logic [3:0] pos;
    logic [31:0] ctr;
    logic out_load;
    logic [7:0] r_obyte;
    logic r_olast;

    assign pready = 1'b1;
    assign reg_idx = paddr[5:3];
    assign cfg_wr = psel && penable && pwrite && (reg_idx < 3'(NumKeyRegs));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NumKeyRegs; i++) begin
                r_key[i] <= 64'd0;
            end
        end else if (cfg_wr) begin
            r_key[reg_idx] <= pwdata;
        end
    end

    always_comb begin
        prdata = 64'd0;
        if (reg_idx < 3'(NumKeyRegs)) begin
            prdata = r_key[reg_idx];
        end
        for (int i = 0; i < NumKeyRegs; i++) begin
            key_flat[i*64 +: 64] = r_key[i];
        end
    end

    arxks_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_last      (i_last_byte),
        .i_out_stall (i_stall),
        .i_cfg_wr    (cfg_wr),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_stall  (o_stall),
        .o_out_load  (out_load),
        .o_pos       (pos),
        .o_ctr       (ctr),
        .o_out_valid (o_valid)
    );

    arxks_datapath #(.ROUNDS(ROUNDS)) u_dp (
        .i_clk (i_clk),
        .i_key (key_flat),
        .i_ctr (ctr),
        .i_cmd (cmd),
        .o_sts (sts),
        .o_ks  (ks)
    );

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_obyte <= i_data_byte ^ ks[{pos, 3'b000} +: 8];
            r_olast <= i_last_byte;
        end
    end

    assign o_out_byte = r_obyte;
    assign o_out_last = r_olast;

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_out_byte))
    `ASSERT_IMPL(a_no_take_full, i_clk, i_rst_n, (o_valid && i_stall) |-> o_stall)
    `ASSERT_NEXT(a_take_valid, i_clk, i_rst_n, i_valid && !o_stall, o_valid)
endmodule
`default_nettype wire

>>> hdl/arxks_datapath.sv
`default_nettype none
module arxks_datapath #(
    parameter int unsigned ROUNDS = 24
) (
    input  wire logic               i_clk,
    input  wire logic [6*64-1:0]    i_key,
    input  wire logic [31:0]        i_ctr,
    input  wire arxks_pkg::t_dp_cmd i_cmd,
    output arxks_pkg::t_dp_sts      o_sts,
    output logic [127:0]            o_ks
);
    import arxks_pkg::*;
    localparam int unsigned IW = $clog2(ROUNDS + 1);

    logic [31:0] r_rw [ROUNDS];
    logic [31:0] r_win [8];
    logic [IW-1:0] r_idx;
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [31:0] r_rwq;
    logic [127:0] r_ks;
    logic [31:0] n_w;
    logic [31:0] a1, b1, c1, d1, a2, b2, c2, d2;
    logic [31:0] k8, k9, k10, k11;
    logic [31:0] mulp;

    assign k8 = i_key[4*64 +: 32];
    assign k9 = i_key[4*64+32 +: 32];
    assign k10 = i_key[5*64 +: 32];
    assign k11 = i_key[5*64+32 +: 32];

    // expansion: window of last 8 words, one new word per cycle
    assign mulp = 32'(r_idx) * GoldenConst;
    assign n_w = (rotl32(r_win[7], 5) ^ r_win[1]) + (mulp ^ r_win[0]);

    always_comb begin
        a1 = r_a + r_b;
        d1 = rotl32(r_d ^ a1, 16);
        c1 = r_c + d1;
        b1 = rotl32(r_b ^ c1, 12);
        a2 = a1 + b1;
        d2 = rotl32(d1 ^ a2, 8);
        c2 = c1 + d2;
        b2 = rotl32(b1 ^ c2, 7);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_key) begin
            for (int i = 0; i < 8; i++) begin
                r_win[i] <= i_key[i*32 +: 32];
            end
            r_idx <= IW'(0);
        end else if (i_cmd.exp_step) begin
            if (r_idx < IW'(8)) begin
                r_rw[r_idx[$clog2(ROUNDS)-1:0]] <= r_win[r_idx[2:0]];
            end else begin
                r_rw[r_idx[$clog2(ROUNDS)-1:0]] <= n_w;
                for (int i = 0; i < 7; i++) begin
                    r_win[i] <= r_win[i+1];
                end
                r_win[7] <= n_w;
            end
            r_idx <= r_idx + IW'(1);
        end else if (i_cmd.blk_init) begin
            r_a <= k8 ^ i_ctr;
            r_b <= k9 ^ ~i_ctr;
            r_c <= k10 ^ ConstC;
            r_d <= k11 ^ ConstD;
            r_rwq <= r_rw[0];
            r_idx <= IW'(1);
        end else if (i_cmd.rnd_step) begin
            r_a <= a2 ^ r_rwq;
            r_b <= b2;
            r_c <= c2;
            r_d <= d2;
            if (r_idx < IW'(ROUNDS)) begin
                r_rwq <= r_rw[r_idx[$clog2(ROUNDS)-1:0]];
            end
            r_idx <= r_idx + IW'(1);
        end
        if (i_cmd.ks_load) begin
            r_ks <= {d2, c2, b2, a2 ^ r_rwq};
        end
    end

    // window is primed after 8 copies: the first 8 words equal key words 0..7
    assign o_sts.exp_done = (r_idx == IW'(ROUNDS - 1)) && i_cmd.exp_step;
    assign o_sts.rnd_done = (r_idx == IW'(ROUNDS)) && i_cmd.rnd_step;
    assign o_ks = r_ks;
endmodule
`default_nettype wire

>>> hdl/arxks_ctrl.sv
`default_nettype none
module arxks_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_last,
    input  wire logic               i_out_stall,
    input  wire logic               i_cfg_wr,
    input  wire arxks_pkg::t_dp_sts i_sts,
    output arxks_pkg::t_dp_cmd      o_cmd,
    output logic                    o_in_stall,
    output logic                    o_out_load,
    output logic [3:0]              o_pos,
    output logic [31:0]             o_ctr,
    output logic                    o_out_valid
);
    import arxks_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_LOADK, ST_EXP, ST_INIT, ST_RND, ST_EMIT
    } t_state;

    t_state r_state;
    logic r_sched_ok;
    logic [3:0] r_pos;
    logic [31:0] r_ctr;
    logic r_ovalid;
    logic take;

    // accept when block ready and output slot free
    assign o_in_stall = !(r_state == ST_IDLE && (r_pos != 4'd0) && (!r_ovalid || !i_out_stall))
        && !(r_state == ST_EMIT && (!r_ovalid || !i_out_stall));
    assign take = i_in_valid && !o_in_stall;

    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_LOADK: o_cmd.load_key = 1'b1;
            ST_EXP: o_cmd.exp_step = 1'b1;
            ST_INIT: o_cmd.blk_init = 1'b1;
            ST_RND: begin
                o_cmd.rnd_step = 1'b1;
                o_cmd.ks_load = i_sts.rnd_done;
            end
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_sched_ok <= 1'b0;
            r_pos <= 4'd0;
            r_ctr <= 32'd0;
            r_ovalid <= 1'b0;
        end else begin
            if (take) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_wr) begin
                r_sched_ok <= 1'b0;
            end else if (i_sts.exp_done) begin
                r_sched_ok <= 1'b1;
            end
            case (r_state)
                ST_IDLE: begin
                    if (take) begin
                        if (i_last) begin
                            r_pos <= 4'd0;
                            r_ctr <= 32'd0;
                        end else begin
                            r_pos <= r_pos + 4'd1;
                            if (r_pos == 4'd15) begin
                                r_ctr <= r_ctr + 32'd1;
                            end
                        end
                    end else if (i_in_valid && r_pos == 4'd0 && !i_cfg_wr) begin
                        r_state <= r_sched_ok ? ST_INIT : ST_LOADK;
                    end
                end
                ST_LOADK: r_state <= ST_EXP;
                ST_EXP: begin
                    if (i_sts.exp_done) begin
                        r_state <= ST_INIT;
                    end
                end
                ST_INIT: r_state <= ST_RND;
                ST_RND: begin
                    if (i_sts.rnd_done) begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (take) begin
                        r_state <= ST_IDLE;
                        if (i_last) begin
                            r_ctr <= 32'd0;
                        end else begin
                            r_pos <= 4'd1;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out_load = take;
    assign o_pos = r_pos;
    assign o_ctr = r_ctr;
    assign o_out_valid = r_ovalid;
endmodule
`default_nettype wire
